// ===== design/mm_pkg.sv =====
// shared types and codes for the matrix multiply block
package mm_pkg;

    // index bits carried in a tag, enough for the largest supported dimension
    localparam int DIM_W = 3;

    localparam logic [2:0] DIM_RESET = 3'd4;

    localparam logic [1:0] ACT_WRITE_A = 2'd0;
    localparam logic [1:0] ACT_WRITE_B = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic signed [31:0] out_value;
        logic               last;
    } result_t;

    // control that travels with a partial sum down the chain
    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] row_idx;
        logic [DIM_W-1:0] col_idx;
        logic             last;
    } tag_t;

endpackage

// ===== design/mm_cell.sv =====
// one chain cell: holds one column of A and one row of B, adds its inner product term
module mm_cell
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 4,
    parameter int ACC_W   = 67
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  logic                                          cell_on,
    input  logic                                          a_write,
    input  logic                                          b_write,
    input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] wr_addr,
    input  logic signed [31:0]                            wr_value,
    input  tag_t                                          tag_in,
    input  logic signed [ACC_W-1:0]                       psum_in,
    output tag_t                                          tag_out,
    output logic signed [ACC_W-1:0]                       psum_out
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic signed [31:0]      a_store_reg [MAX_DIM];
    logic signed [31:0]      b_store_reg [MAX_DIM];

    logic signed [31:0]      a_sel;
    logic signed [31:0]      b_sel;
    logic signed [63:0]      prod_next;
    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] psum_s1_reg;
    logic signed [ACC_W-1:0] psum_next;
    logic signed [ACC_W-1:0] psum_out_reg;
    tag_t                    tag_s1_reg;
    tag_t                    tag_out_reg;

    always_ff @(posedge clk)
    begin
        if (a_write)
        begin
            a_store_reg[wr_addr] <= wr_value;
        end
        if (b_write)
        begin
            b_store_reg[wr_addr] <= wr_value;
        end
    end

    // A entry by output row, B entry by output column
    assign a_sel = a_store_reg[tag_in.row_idx[IDX_W-1:0]];
    assign b_sel = b_store_reg[tag_in.col_idx[IDX_W-1:0]];

    // cells past the inner dimension pass the sum through
    assign prod_next = cell_on ? (64'(a_sel) * 64'(b_sel)) : '0;
    assign psum_next = psum_s1_reg + {{(ACC_W-64){prod_reg[63]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s1_reg  <= '0;
            tag_out_reg <= '0;
        end
        else if (adv)
        begin
            tag_s1_reg  <= tag_in;
            tag_out_reg <= tag_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg     <= prod_next;
            psum_s1_reg  <= psum_in;
            psum_out_reg <= psum_next;
        end
    end

    assign tag_out  = tag_out_reg;
    assign psum_out = psum_out_reg;

endmodule

// ===== design/mm_issue.sv =====
// walks the product elements in row-major order and feeds one tag a cycle into the chain while adv is high
module mm_issue
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           adv,
    input  logic [$clog2(MAX_DIM+1)-1:0]   nr,
    input  logic [$clog2(MAX_DIM+1)-1:0]   nc,
    output tag_t                           tag
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    typedef enum logic {S_IDLE, S_ISSUE} state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    tag_t             tag_reg;
    tag_t             tag_next;
    logic             row_end;
    logic             col_end;

    assign row_end = (({1'b0, i_reg} + 1'b1) == (IDX_W+1)'(nr));
    assign col_end = (({1'b0, j_reg} + 1'b1) == (IDX_W+1)'(nc));

    always_comb
    begin
        tag_next.valid   = (state_reg == S_ISSUE);
        tag_next.row_idx = DIM_W'(i_reg);
        tag_next.col_idx = DIM_W'(j_reg);
        tag_next.last    = row_end && col_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_ISSUE;
                        i_reg     <= '0;
                        j_reg     <= '0;
                    end
                end
                S_ISSUE:
                begin
                    if (adv)
                    begin
                        if (col_end)
                        begin
                            j_reg <= '0;
                            if (row_end)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (adv)
            begin
                tag_reg <= tag_next;
            end
        end
    end

    assign tag = tag_reg;

endmodule

// ===== design/mm_out.sv =====
// rounds and saturates the finished sum and holds the result word for the consumer
module mm_out
    import mm_pkg::*;
#(
    parameter int ACC_W = 67
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tag_t                    tag_in,
    input  logic signed [ACC_W-1:0] psum_in,
    input  logic                    result_stall,
    output logic                    adv,
    output logic                    result_valid,
    output result_t                 result
);

    logic [ACC_W-1:0]      biased;
    logic [ACC_W-48:0]     hi_bits;
    logic signed [31:0]    sat_value;
    logic                  valid_reg;
    result_t               result_reg;
    result_t               result_next;

    // round half up at bit 16, then keep the Q16.16 part
    assign biased  = psum_in + ACC_W'(32'h0000_8000);
    assign hi_bits = biased[ACC_W-1:47];

    always_comb
    begin
        if ((&hi_bits) || !(|hi_bits))
        begin
            sat_value = biased[47:16];
        end
        else if (biased[ACC_W-1])
        begin
            sat_value = 32'sh8000_0000;
        end
        else
        begin
            sat_value = 32'sh7fff_ffff;
        end
        result_next.out_row   = tag_in.row_idx[1:0];
        result_next.out_col   = tag_in.col_idx[1:0];
        result_next.out_value = sat_value;
        result_next.last      = tag_in.last;
    end

    // the whole chain moves only when the output word can be replaced
    assign adv = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tag_in.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/matrix_multiply.sv =====
// top level of the dense matrix multiply block: config, store write decode and cell chain
//
// Elements of A and B are loaded one word per cycle while no compute runs, into a row of
// MAX_DIM cells; cell k keeps column k of A and row k of B, so a write of A lands in the cell
// of its column and a write of B in the cell of its row. A compute word starts a sequencer that
// sends one product element a cycle into the chain while the chain advances; each cell
// multiplies and adds its term in two register stages, and a final stage rounds to Q16.16 and
// saturates. Result words come out one a cycle while the consumer keeps up; a stall on the
// result side freezes the whole chain. After a compute word no new input word is taken until
// its last result is taken. The stores hold no reset value and need no clearing pass; only
// written elements may be read.
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int ACC_W = 65 + $clog2(MAX_DIM);

    logic [2:0]              rows_a_reg;
    logic [2:0]              inner_dim_reg;
    logic [2:0]              cols_b_reg;
    logic                    busy_reg;

    logic [CNT_W-1:0]        nr;
    logic [CNT_W-1:0]        nk;
    logic [CNT_W-1:0]        nc;
    logic                    item_accept;
    logic                    start;
    logic                    in_range;
    logic                    wr_a;
    logic                    wr_b;
    logic [IDX_W+1:0]        row_wide;
    logic [IDX_W+1:0]        col_wide;
    logic [IDX_W-1:0]        row_addr;
    logic [IDX_W-1:0]        col_addr;
    logic [IDX_W-1:0]        wr_addr;
    logic                    adv;
    logic                    last_taken;

    tag_t                    chain_tag  [MAX_DIM+1];
    logic signed [ACC_W-1:0] chain_psum [MAX_DIM+1];

    // zero acts as one, anything above the array size acts as the array size
    function automatic logic [CNT_W-1:0] clamp_dim(input logic [2:0] v);
        logic [CNT_W-1:0] r;
        if (v == 3'd0)
        begin
            r = CNT_W'(1);
        end
        else if (4'(v) > 4'(MAX_DIM))
        begin
            r = CNT_W'(MAX_DIM);
        end
        else
        begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    assign nr = clamp_dim(rows_a_reg);
    assign nk = clamp_dim(inner_dim_reg);
    assign nc = clamp_dim(cols_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign item_stall  = busy_reg;
    assign item_accept = item_valid && !item_stall;
    assign start       = item_accept && (item.action == ACT_COMPUTE);
    assign last_taken  = result_valid && !result_stall && result.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (last_taken)
        begin
            busy_reg <= 1'b0;
        end
    end

    // store write decode
    assign in_range = (4'(item.row) < 4'(MAX_DIM)) && (4'(item.col) < 4'(MAX_DIM));
    assign wr_a     = item_accept && (item.action == ACT_WRITE_A) && in_range;
    assign wr_b     = item_accept && (item.action == ACT_WRITE_B) && in_range;
    assign row_wide = (IDX_W+2)'(item.row);
    assign col_wide = (IDX_W+2)'(item.col);
    assign row_addr = row_wide[IDX_W-1:0];
    assign col_addr = col_wide[IDX_W-1:0];
    assign wr_addr  = wr_a ? row_addr : col_addr;

    mm_issue #(
        .MAX_DIM (MAX_DIM)
    ) u_issue (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .adv   (adv),
        .nr    (nr),
        .nc    (nc),
        .tag   (chain_tag[0])
    );

    assign chain_psum[0] = '0;

    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        mm_cell #(
            .MAX_DIM (MAX_DIM),
            .ACC_W   (ACC_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_on  (4'(k) < 4'(nk)),
            .a_write  (wr_a && (4'(item.col) == 4'(k))),
            .b_write  (wr_b && (4'(item.row) == 4'(k))),
            .wr_addr  (wr_addr),
            .wr_value (item.value),
            .tag_in   (chain_tag[k]),
            .psum_in  (chain_psum[k]),
            .tag_out  (chain_tag[k+1]),
            .psum_out (chain_psum[k+1])
        );
    end

    mm_out #(
        .ACC_W (ACC_W)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag_in       (chain_tag[MAX_DIM]),
        .psum_in      (chain_psum[MAX_DIM]),
        .result_stall (result_stall),
        .adv          (adv),
        .result_valid (result_valid),
        .result       (result)
    );

    // results only ever belong to a compute word in flight
    a_result_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> busy_reg
    ) else $error("result word outside a compute");

    // nothing follows the flagged last word
    a_nothing_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        last_taken |=> !result_valid
    ) else $error("result word after last");

    // a new compute starts with an empty output
    a_start_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> !result_valid
    ) else $error("stale result word at compute start");

endmodule
